/* sv/pcr_pkg.sv */
// Shared widths, defaults, payload structs and control types for the
// permutation crossover repair block. No dependencies.
package pcr_pkg;

  localparam int GENE_W          = 6;   // city number width
  localparam int CITY_W          = 7;   // city count and pivot width
  localparam int MAX_CITIES_DEF  = 64;
  localparam int CITY_MIN        = 2;

  typedef struct packed {
    logic [GENE_W-1:0] gene_from_first;
    logic [GENE_W-1:0] gene_from_second;
    logic [CITY_W-1:0] pivot;
  } parent_item_t;

  typedef struct packed {
    logic [GENE_W-1:0] child_gene;
    logic              was_replaced;
    logic              last;
  } child_item_t;

  typedef enum logic {
    PH_LOAD,
    PH_EMIT
  } phase_t;

  // Control from the sequencer to the city maps.
  typedef struct packed {
    logic              clear;
    logic              set_valid;
    logic [GENE_W-1:0] set_city;
    logic              scan_en;
    logic              consume;
    logic              mark_valid;
    logic [GENE_W-1:0] mark_city;
    logic [GENE_W-1:0] query_city;
  } map_ctrl_t;

  // Status back from the city maps.
  typedef struct packed {
    logic              miss_ok;
    logic [GENE_W-1:0] miss_city;
    logic              emitted;
  } map_stat_t;

endpackage

/* sv/pcr_stream_if.sv */
// Valid/ready stream interface with a typed payload.
// The payload type is supplied by the instantiating side.
interface pcr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/pcr_child_ram.sv */
// Child gene store: one write port, one read port, registered read data.
// Depends on pcr_pkg for the gene width.
module pcr_child_ram import pcr_pkg::*; #(
  parameter int DEPTH  = MAX_CITIES_DEF,
  parameter int ADDR_W = $clog2(MAX_CITIES_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [GENE_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [GENE_W-1:0] rdata
);

  logic [GENE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/pcr_city_maps.sv */
// Present and emitted city bitmaps plus the missing-city cursor.
// Depends on pcr_pkg for the control and status structs.
module pcr_city_maps import pcr_pkg::*; #(
  parameter int MAX_CITIES = MAX_CITIES_DEF,
  parameter int CNT_W      = $clog2(MAX_CITIES_DEF + 1),
  parameter int IDX_W      = $clog2(MAX_CITIES_DEF)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] n,
  input  map_ctrl_t        ctrl,
  output map_stat_t        stat
);

  logic [MAX_CITIES-1:0] present_map;
  logic [MAX_CITIES-1:0] emitted_map;
  logic [CNT_W-1:0]      cursor;
  logic [IDX_W-1:0]      cur_idx;
  logic                  cur_live;
  logic                  advance;

  assign cur_idx  = cursor[IDX_W-1:0];
  assign cur_live = ctrl.scan_en && (cursor < n);
  // the cursor walks over present cities on its own, and parks on a missing one
  assign advance  = cur_live && present_map[cur_idx];

  assign stat.miss_ok   = cur_live && !present_map[cur_idx];
  assign stat.miss_city = GENE_W'(cursor);
  assign stat.emitted   = emitted_map[ctrl.query_city[IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      present_map <= '0;
      emitted_map <= '0;
      cursor      <= '0;
    end else begin
      if (ctrl.set_valid) begin
        present_map[ctrl.set_city[IDX_W-1:0]] <= 1'b1;
      end
      if (ctrl.mark_valid) begin
        emitted_map[ctrl.mark_city[IDX_W-1:0]] <= 1'b1;
      end
      if (ctrl.consume || advance) begin
        cursor <= cursor + 1'b1;
      end
    end
  end

endmodule

/* sv/permutation_crossover_repair.sv */
// Emit path: once the last gene of a child is taken, the phase register turns to emit; the
// gene store read and the output register then lie before the first repaired gene is offered.
// Throughput: one gene taken per cycle while loading; then one result per cycle while the
// receiver is ready, save where the cursor steps over present cities before a replacement.
// Reset: city_count is 64, maps and counters clear; the gene store is not cleared.
// A configuration write also discards the child being loaded or emitted, bar a result in the output register.
module permutation_crossover_repair import pcr_pkg::*; #(
  parameter int MAX_CITIES = MAX_CITIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CITY_W-1:0] cfg_wdata,
  pcr_stream_if.sink        parents,
  pcr_stream_if.source      child
);

  localparam int CNT_W = $clog2(MAX_CITIES + 1);
  localparam int IDX_W = $clog2(MAX_CITIES);

  phase_t            phase;
  phase_t            phase_next;
  logic              load_en;
  logic              emit_en;

  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  n_next;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  dec_idx;
  logic              g_valid;

  logic              load_fire;
  logic              load_last;
  logic [GENE_W-1:0] gene_sel;
  logic              issue;
  logic [GENE_W-1:0] g;
  logic              keep;
  logic              out_free;
  logic              g_fire;
  logic              dec_last;
  logic [GENE_W-1:0] dec_gene;

  logic              out_valid;
  child_item_t       out_data;

  map_ctrl_t         mctrl;
  map_stat_t         mstat;

  // ---------------- phase control ----------------
  always_comb begin
    phase_next = phase;
    if (cfg_we) begin
      phase_next = PH_LOAD;
    end else begin
      case (phase)
        PH_LOAD: if (load_fire && load_last) phase_next = PH_EMIT;
        PH_EMIT: if (g_fire && dec_last) phase_next = PH_LOAD;
        default: phase_next = PH_LOAD;
      endcase
    end
  end

  always_comb begin
    load_en = 1'b0;
    emit_en = 1'b0;
    case (phase)
      PH_LOAD: load_en = 1'b1;
      PH_EMIT: emit_en = 1'b1;
      default: load_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LOAD;
    end else begin
      phase <= phase_next;
    end
  end

  // ---------------- city count register ----------------
  always_comb begin
    if (cfg_wdata < CITY_W'(CITY_MIN)) begin
      n_next = CNT_W'(CITY_MIN);
    end else if (cfg_wdata > CITY_W'(MAX_CITIES)) begin
      n_next = CNT_W'(MAX_CITIES);
    end else begin
      n_next = CNT_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= CNT_W'(MAX_CITIES);
    end else if (cfg_we) begin
      n <= n_next;
    end
  end

  // ---------------- load side ----------------
  assign parents.ready = load_en;
  assign load_fire     = parents.valid && load_en;
  assign load_last     = (pos == n - CNT_W'(1));
  assign gene_sel      = (CITY_W'(pos) < parents.data.pivot) ? parents.data.gene_from_first
                                                              : parents.data.gene_from_second;

  // ---------------- emit side ----------------
  // decision stage holds the registered gene from the store; a read is issued only when it is empty or frees
  assign issue    = emit_en && (rd_idx < n) && (!g_valid || g_fire);
  assign keep     = (CITY_W'(g) < CITY_W'(n)) && !mstat.emitted;
  assign out_free = !out_valid || child.ready;
  assign g_fire   = g_valid && out_free && (keep || mstat.miss_ok);
  assign dec_last = (dec_idx == n - CNT_W'(1));
  assign dec_gene = keep ? g : mstat.miss_city;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      pos     <= '0;
      rd_idx  <= '0;
      dec_idx <= '0;
      g_valid <= 1'b0;
    end else begin
      if (load_fire) begin
        pos <= pos + 1'b1;
      end
      if (issue) begin
        rd_idx  <= rd_idx + 1'b1;
        g_valid <= 1'b1;
      end else if (g_fire) begin
        g_valid <= 1'b0;
      end
      if (g_fire) begin
        dec_idx <= dec_idx + 1'b1;
      end
      if (g_fire && dec_last) begin
        pos     <= '0;
        rd_idx  <= '0;
        dec_idx <= '0;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (g_fire) begin
      out_valid <= 1'b1;
    end else if (child.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (g_fire) begin
      out_data.child_gene   <= dec_gene;
      out_data.was_replaced <= !keep;
      out_data.last         <= dec_last;
    end
  end

  assign child.valid = out_valid;
  assign child.data  = out_data;

  // ---------------- storage ----------------
  pcr_child_ram #(
    .DEPTH  (MAX_CITIES),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (load_fire),
    .waddr (pos[IDX_W-1:0]),
    .wdata (gene_sel),
    .re    (issue),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (g)
  );

  always_comb begin
    mctrl.clear      = cfg_we || (g_fire && dec_last);
    mctrl.set_valid  = load_fire && (CITY_W'(gene_sel) < CITY_W'(n));
    mctrl.set_city   = gene_sel;
    mctrl.scan_en    = emit_en;
    mctrl.consume    = g_fire && !keep;
    mctrl.mark_valid = g_fire;
    mctrl.mark_city  = dec_gene;
    mctrl.query_city = g;
  end

  pcr_city_maps #(
    .MAX_CITIES (MAX_CITIES),
    .CNT_W      (CNT_W),
    .IDX_W      (IDX_W)
  ) u_maps (
    .clk  (clk),
    .rst  (rst),
    .n    (n),
    .ctrl (mctrl),
    .stat (mstat)
  );

endmodule

/* sim/pcr_checker.sv */
// Checker for permutation_crossover_repair: predicts the repaired child from the
// accepted parent transactions and compares every child transaction against it.
// Depends on pcr_pkg.
module pcr_checker import pcr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CITY_W-1:0] cfg_wdata,
  input  logic              parent_valid,
  input  logic              parent_ready,
  input  parent_item_t      parent_data,
  input  logic              child_valid,
  input  logic              child_ready,
  input  child_item_t       child_data,
  output int unsigned       fail_count,
  output int unsigned       pending
);

  localparam int MAXC = MAX_CITIES_DEF;

  logic [CITY_W-1:0] count_reg;
  logic [GENE_W-1:0] loaded_genes [MAXC];
  bit                present [MAXC];
  bit                used [MAXC];
  int                loaded;
  int                cursor;
  child_item_t       repaired_q [$];
  int unsigned       mismatches = 0;
  int unsigned       outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  function automatic int cities();
    int n;
    n = count_reg;
    if (n < CITY_MIN) n = CITY_MIN;
    if (n > MAXC) n = MAXC;
    return n;
  endfunction

  task automatic restart_child();
    for (int i = 0; i < MAXC; i++) begin
      present[i] = 1'b0;
      used[i]    = 1'b0;
    end
    loaded = 0;
    cursor = 0;
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // First copy of a city is kept; duplicates and invalid genes take the
  // smallest city missing from the whole child.
  task automatic repair_child();
    int          n;
    int          g;
    child_item_t e;
    n = cities();
    for (int i = 0; i < n; i++) begin
      g = loaded_genes[i];
      if (g < n && !used[g]) begin
        used[g] = 1'b1;
        e.child_gene   = GENE_W'(g);
        e.was_replaced = 1'b0;
      end else begin
        while (cursor < n && present[cursor]) cursor++;
        if (cursor < n) begin
          e.child_gene = GENE_W'(cursor);
          used[cursor] = 1'b1;
          cursor++;
        end else begin
          e.child_gene = '0;
        end
        e.was_replaced = 1'b1;
      end
      e.last = (i == n - 1);
      repaired_q = {repaired_q, e};
    end
  endtask

  task automatic take_gene(input parent_item_t it);
    int n;
    int gene;
    n = cities();
    if (loaded >= n) restart_child();
    gene = (loaded < int'(it.pivot)) ? int'(it.gene_from_first) : int'(it.gene_from_second);
    loaded_genes[loaded] = GENE_W'(gene);
    if (gene < n) present[gene] = 1'b1;
    loaded++;
    if (loaded == n) begin
      repair_child();
      restart_child();
    end
  endtask

  task automatic check_result(input child_item_t got);
    child_item_t want;
    if (repaired_q.size() == 0) begin
      report_mismatch($sformatf("unexpected child gene %0d", got.child_gene));
      return;
    end
    want = repaired_q.pop_front();
    if (got.child_gene !== want.child_gene)
      report_mismatch($sformatf("child_gene %0d, want %0d", got.child_gene, want.child_gene));
    if (got.was_replaced !== want.was_replaced)
      report_mismatch($sformatf("was_replaced %b, want %b (gene %0d)",
                                got.was_replaced, want.was_replaced, want.child_gene));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %b, want %b (gene %0d)",
                                got.last, want.last, want.child_gene));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      count_reg = CITY_W'(MAX_CITIES_DEF);
      restart_child();
      repaired_q.delete();
    end else begin
      // a register write throws away the partly loaded child
      if (cfg_we) begin
        count_reg = cfg_wdata;
        restart_child();
      end
      if (child_valid && child_ready) check_result(child_data);
      if (parent_valid && parent_ready) take_gene(parent_data);
    end
    outstanding <= repaired_q.size();
  end

endmodule

/* sim/tb.sv */
// Testbench top for permutation_crossover_repair: clock, reset, parent stimulus,
// child back-pressure and the verdict. Depends on pcr_pkg, pcr_stream_if,
// permutation_crossover_repair and pcr_checker.
module tb;
  import pcr_pkg::*;

  localparam int ITEM_GOAL   = 470;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 3 * MAX_CITIES_DEF + 8;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [CITY_W-1:0] cfg_wdata;
  int                send_idle_pct = 0;
  int                stall_pct = 0;
  logic              hold_active = 1'b0;
  event              hold_go;
  int                items_sent = 0;
  int unsigned       fail_count;
  int unsigned       pending;
  int                count_plan [16] = '{64, 3, 7, 2, 12, 65, 5, 9, 127, 4, 16, 6, 1, 10, 0, 8};

  pcr_stream_if #(.payload_t(parent_item_t)) parents_ch ();
  pcr_stream_if #(.payload_t(child_item_t))  child_ch ();

  permutation_crossover_repair dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .parents   (parents_ch),
    .child     (child_ch)
  );

  pcr_checker chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .parent_valid (parents_ch.valid),
    .parent_ready (parents_ch.ready),
    .parent_data  (parents_ch.data),
    .child_valid  (child_ch.valid),
    .child_ready  (child_ch.ready),
    .child_data   (child_ch.data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst || hold_active) child_ch.ready <= 1'b0;
    else child_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // one long receiver hold-off so the block fills up and stalls its input
  initial begin
    @(hold_go);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  function automatic int cities_for(input int v);
    if (v < CITY_MIN) return CITY_MIN;
    if (v > MAX_CITIES_DEF) return MAX_CITIES_DEF;
    return v;
  endfunction

  task automatic set_mode(input int m);
    case (m)
      0: begin send_idle_pct = 0;  stall_pct <= 0;  end
      1: begin send_idle_pct = 55; stall_pct <= 0;  end
      2: begin send_idle_pct = 0;  stall_pct <= 55; end
      default: begin send_idle_pct = 27; stall_pct <= 27; end
    endcase
  endtask

  task automatic set_count(input int v);
    cfg_we    <= 1'b1;
    cfg_wdata <= CITY_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic put_gene(input int first, input int second, input int pivot);
    parent_item_t it;
    it.gene_from_first  = GENE_W'(first);
    it.gene_from_second = GENE_W'(second);
    it.pivot            = CITY_W'(pivot);
    while ($urandom_range(99) < send_idle_pct) begin
      parents_ch.valid <= 1'b0;
      @(posedge clk);
    end
    parents_ch.valid <= 1'b1;
    parents_ch.data  <= it;
    do @(posedge clk); while (!parents_ch.ready);
    items_sent++;
  endtask

  // waits out every expected transaction, then the block's worst-case latency
  task automatic drain();
    parents_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Two shuffled parents crossed at one cut, a gene in ten with a random pivot; a quarter of the children are noise.
  // len below n leaves a partial child for the next register write to discard.
  task automatic send_child(input int n, input int len);
    int first_p [MAX_CITIES_DEF];
    int second_p [MAX_CITIES_DEF];
    int j;
    int tmp;
    int cut;
    bit noisy;
    for (int i = 0; i < n; i++) begin
      first_p[i]  = i;
      second_p[i] = i;
    end
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = first_p[i]; first_p[i] = first_p[j]; first_p[j] = tmp;
      j = $urandom_range(0, i);
      tmp = second_p[i]; second_p[i] = second_p[j]; second_p[j] = tmp;
    end
    noisy = ($urandom_range(3) == 0);
    cut   = $urandom_range(0, n);
    for (int i = 0; i < len; i++) begin
      if (noisy)
        put_gene($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 127));
      else
        put_gene(first_p[i], second_p[i],
                 ($urandom_range(9) == 0) ? $urandom_range(0, 127) : cut);
    end
  endtask

  initial begin
    int phase;
    int cfg;
    int n;
    int phase_items;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    parents_ch.valid = 1'b0;
    parents_ch.data  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_mode(3);
    set_count(2);
    put_gene(1, 0, 127);   // all from first, no repair
    put_gene(0, 63, 127);
    put_gene(5, 1, 0);     // all from second, duplicate
    put_gene(5, 1, 0);
    put_gene(63, 63, 64);  // invalid cities from first
    put_gene(62, 0, 64);
    put_gene(0, 1, 1);     // pivot changes within the child
    put_gene(0, 1, 0);
    drain();
    set_count(0);          // clamps to the minimum
    put_gene(1, 1, 2);
    put_gene(1, 1, 2);
    drain();
    set_count(1);
    put_gene(0, 0, 0);     // partial child, dropped by the next write
    drain();
    set_count(127);        // clamps to the maximum
    set_count(5);
    put_gene(4, 0, 3);
    put_gene(4, 0, 3);
    put_gene(0, 9, 3);
    put_gene(1, 63, 3);
    put_gene(1, 2, 3);
    drain();

    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      set_mode(phase % 4);
      cfg = (phase < 16) ? count_plan[phase] : $urandom_range(2, 20);
      set_count(cfg);
      n = cities_for(cfg);
      if (phase == 0) -> hold_go;
      phase_items = 0;
      do begin
        send_child(n, n);
        phase_items += n;
      end while (phase_items < 36);
      if ($urandom_range(1) == 1) send_child(n, $urandom_range(1, n - 1));
      drain();
      phase++;
    end

    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("tb NOT OK");
    $finish;
  end

endmodule

/* sim.f */
sv/pcr_pkg.sv
sv/pcr_stream_if.sv
sv/pcr_child_ram.sv
sv/pcr_city_maps.sv
sv/permutation_crossover_repair.sv
sim/pcr_checker.sv
sim/tb.sv
